FILE: rtl/core/v2yp_pkg.sv
// Package for the vector-to-yaw/pitch block: widths, fixed-point constants
// and the CORDIC arctangent table. No dependencies.
`default_nettype none

package v2yp_pkg;

    // Field widths of the external items.
    localparam int VEC_W   = 16;
    localparam int YAW_W   = 16;
    localparam int PITCH_W = 15;

    // Datapath: components scaled by 64 into 24-bit signed values.
    localparam int DATA_W  = 24;
    localparam int SCALE_SH = 6;

    // Angle accumulator in 1/512 degree. One bit of headroom over the
    // 18 bits the stored state needs, so a turned start plus the table sum
    // cannot wrap.
    localparam int ACC_W   = 19;

    // Arctangent table.
    localparam int ATAN_LEN = 24;
    localparam int ATAN_W   = 15;
    localparam int ITER_W   = 5;

    // Inverse CORDIC gain in Q0.20, with the width of its fraction.
    localparam int GAIN_W   = 20;
    localparam logic [GAIN_W-1:0] INV_GAIN = 20'd636751;

    // Half turn in accumulator units (180 degrees times 512).
    localparam logic signed [ACC_W-1:0] HALF_TURN = 19'sd92160;

    // Output limits in 1/128 degree.
    localparam logic signed [ACC_W-1:0] YAW_LIM   = 19'sd23040;
    localparam logic signed [ACC_W-1:0] PITCH_LIM = 19'sd11520;

    // atan(2^-i) in degrees times 512, rounded to nearest.
    function automatic logic [ATAN_W-1:0] f_atan(input logic [ITER_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 15'd23040;
            5'd1:    v = 15'd13601;
            5'd2:    v = 15'd7187;
            5'd3:    v = 15'd3648;
            5'd4:    v = 15'd1831;
            5'd5:    v = 15'd916;
            5'd6:    v = 15'd458;
            5'd7:    v = 15'd229;
            5'd8:    v = 15'd115;
            5'd9:    v = 15'd57;
            5'd10:   v = 15'd29;
            5'd11:   v = 15'd14;
            5'd12:   v = 15'd7;
            5'd13:   v = 15'd4;
            5'd14:   v = 15'd2;
            5'd15:   v = 15'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vector_to_yaw_pitch.sv
// Top level of the vector-to-yaw/pitch converter: one shared CORDIC
// vectoring stage run twice under a small sequencer. Depends on v2yp_pkg.
`default_nettype none

//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | into      | i_in_valid / o_in_stall    | i_vec_x, i_vec_y, i_vec_z (Q8.8)
//  out     | out of    | o_out_valid / i_out_stall  | o_yaw_angle, o_pitch_angle
//
// A vector goes from its transfer through the yaw pass, gain correction, the
// pitch pass and the finishing state into the output register; each pass runs
// CORDIC_STEPS steps, capped at 24. The single micro-rotation stage is the
// limit: it runs the steps for yaw and then those for pitch, and the input
// stalls until the result leaves the finishing state. A vector with zero
// horizontal part skips both passes. Reset is synchronous and active low and
// returns the sequencer to idle with an empty output register. A stall on the
// output holds the result; the next vector is still taken, and its result
// waits in the finishing state until the output register frees up.

module vector_to_yaw_pitch #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  logic signed [v2yp_pkg::VEC_W-1:0]   i_vec_x,
    input  wire  logic signed [v2yp_pkg::VEC_W-1:0]   i_vec_y,
    input  wire  logic signed [v2yp_pkg::VEC_W-1:0]   i_vec_z,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [v2yp_pkg::YAW_W-1:0]    o_yaw_angle,
    output logic signed [v2yp_pkg::PITCH_W-1:0]  o_pitch_angle
);

    import v2yp_pkg::*;

    // The table has 24 entries; more steps than that would add nothing.
    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam logic [ITER_W-1:0] LAST_STEP = ITER_W'(STEPS - 1);
    localparam int PROD_W = DATA_W - 1 + GAIN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_GAIN,
        ST_PASS2,
        ST_HOLD
    } t_state;

    t_state                     r_state;
    logic [ITER_W-1:0]          r_iter;
    logic signed [DATA_W-1:0]   r_x;
    logic signed [DATA_W-1:0]   r_y;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [VEC_W-1:0]    r_z;
    logic                       r_hzero;
    logic signed [YAW_W-1:0]    r_yaw;
    logic                       r_out_valid;
    logic signed [YAW_W-1:0]    r_yaw_out;
    logic signed [PITCH_W-1:0]  r_pitch_out;

    logic                       in_xfer;
    logic                       out_free;
    logic signed [DATA_W-1:0]   n_x_load;
    logic signed [DATA_W-1:0]   n_y_load;
    logic signed [ACC_W-1:0]    n_acc_load;
    logic signed [DATA_W-1:0]   x_sh;
    logic signed [DATA_W-1:0]   y_sh;
    logic signed [ACC_W-1:0]    atan_ext;
    logic signed [DATA_W-1:0]   n_x_step;
    logic signed [DATA_W-1:0]   n_y_step;
    logic signed [ACC_W-1:0]    n_acc_step;
    logic [PROD_W-1:0]          gain_prod;
    logic [PROD_W-1:0]          gain_rnd;
    logic signed [DATA_W-1:0]   len;
    logic signed [DATA_W-1:0]   neg_z;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [ACC_W-1:0]    acc_q;
    logic signed [ACC_W-1:0]    yaw_sat;
    logic signed [ACC_W-1:0]    pitch_sat;
    logic signed [PITCH_W-1:0]  pitch_res;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_yaw_angle   = r_yaw_out;
    assign o_pitch_angle = r_pitch_out;

    // Load: scale by 64 and, for negative x, turn the vector by a half turn.
    always_comb begin
        logic signed [DATA_W-1:0] sx;
        logic signed [DATA_W-1:0] sy;
        sx = {{(DATA_W-VEC_W-SCALE_SH){i_vec_x[VEC_W-1]}}, i_vec_x, SCALE_SH'(0)};
        sy = {{(DATA_W-VEC_W-SCALE_SH){i_vec_y[VEC_W-1]}}, i_vec_y, SCALE_SH'(0)};
        if (i_vec_x[VEC_W-1]) begin
            n_x_load   = -sx;
            n_y_load   = -sy;
            n_acc_load = i_vec_y[VEC_W-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            n_x_load   = sx;
            n_y_load   = sy;
            n_acc_load = '0;
        end
    end

    // The shared micro-rotation: drive y toward zero, accumulate the angle.
    assign x_sh     = r_x >>> r_iter;
    assign y_sh     = r_y >>> r_iter;
    assign atan_ext = ACC_W'(f_atan(r_iter));

    always_comb begin
        if (!r_y[DATA_W-1]) begin
            n_x_step   = r_x + y_sh;
            n_y_step   = r_y - x_sh;
            n_acc_step = r_acc + atan_ext;
        end else begin
            n_x_step   = r_x - y_sh;
            n_y_step   = r_y + x_sh;
            n_acc_step = r_acc - atan_ext;
        end
    end

    // Gain correction of the horizontal length; x is never negative here
    // and stays below 2^23, so the low bits carry the whole value.
    assign gain_prod = PROD_W'(r_x[DATA_W-2:0]) * PROD_W'(INV_GAIN);
    assign gain_rnd  = gain_prod + (PROD_W'(1) << (GAIN_W - 1));
    assign len       = DATA_W'(gain_rnd[PROD_W-1:GAIN_W]);
    assign neg_z     = -{{(DATA_W-VEC_W-SCALE_SH){r_z[VEC_W-1]}}, r_z, SCALE_SH'(0)};

    // Accumulator to output units: divide by four, rounding half up, saturate.
    assign acc_rnd = r_acc + ACC_W'(2);
    assign acc_q   = acc_rnd >>> 2;

    always_comb begin
        if (acc_q > YAW_LIM) begin
            yaw_sat = YAW_LIM;
        end else if (acc_q < -YAW_LIM) begin
            yaw_sat = -YAW_LIM;
        end else begin
            yaw_sat = acc_q;
        end
        if (acc_q > PITCH_LIM) begin
            pitch_sat = PITCH_LIM;
        end else if (acc_q < -PITCH_LIM) begin
            pitch_sat = -PITCH_LIM;
        end else begin
            pitch_sat = acc_q;
        end
    end

    // With no horizontal part the pitch is straight down for positive z
    // and straight up otherwise, zero included.
    always_comb begin
        if (r_hzero) begin
            if (!r_z[VEC_W-1] && (r_z != '0)) begin
                pitch_res = -PITCH_W'(PITCH_LIM);
            end else begin
                pitch_res = PITCH_W'(PITCH_LIM);
            end
        end else begin
            pitch_res = PITCH_W'(pitch_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the finishing state the hold arm below owns the output register.
            if (r_out_valid && !i_out_stall && (r_state != ST_HOLD)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_z     <= i_vec_z;
                        r_x     <= n_x_load;
                        r_y     <= n_y_load;
                        r_acc   <= n_acc_load;
                        r_iter  <= '0;
                        r_hzero <= (i_vec_x == '0) && (i_vec_y == '0);
                        if ((i_vec_x == '0) && (i_vec_y == '0)) begin
                            r_yaw   <= '0;
                            r_state <= ST_HOLD;
                        end else begin
                            r_state <= ST_PASS1;
                        end
                    end
                end
                ST_PASS1: begin
                    r_x   <= n_x_step;
                    r_y   <= n_y_step;
                    r_acc <= n_acc_step;
                    if (r_iter == LAST_STEP) begin
                        r_iter  <= '0;
                        r_state <= ST_GAIN;
                    end else begin
                        r_iter <= r_iter + ITER_W'(1);
                    end
                end
                ST_GAIN: begin
                    r_yaw   <= YAW_W'(yaw_sat);
                    r_x     <= len;
                    r_y     <= neg_z;
                    r_acc   <= '0;
                    r_state <= ST_PASS2;
                end
                ST_PASS2: begin
                    r_x   <= n_x_step;
                    r_y   <= n_y_step;
                    r_acc <= n_acc_step;
                    if (r_iter == LAST_STEP) begin
                        r_iter  <= '0;
                        r_state <= ST_HOLD;
                    end else begin
                        r_iter <= r_iter + ITER_W'(1);
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_yaw_out   <= r_yaw;
                        r_pitch_out <= pitch_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A transfer in always starts work, so the input is held off next cycle.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input not held off after a transfer");

    // x never goes negative during a pass; a sign flip means the datapath wrapped.
    a_x_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PASS1) || (r_state == ST_PASS2)) |-> !r_x[DATA_W-1])
        else $error("CORDIC x register wrapped");

    // Results leave within their angle ranges.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_yaw_angle <= YAW_W'(YAW_LIM)) && (o_yaw_angle >= -YAW_W'(YAW_LIM))
            && (o_pitch_angle <= PITCH_W'(PITCH_LIM))
            && (o_pitch_angle >= -PITCH_W'(PITCH_LIM))))
        else $error("result angle out of range");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_vector_to_yaw_pitch.sv
// Self-checking testbench for vector_to_yaw_pitch: random and directed vectors
// against an in-bench CORDIC predictor, with valid/stall pressure on both sides.
// Depends on v2yp_pkg and vector_to_yaw_pitch.
`timescale 1ns / 1ps

module tb_vector_to_yaw_pitch;

    import v2yp_pkg::VEC_W;
    import v2yp_pkg::YAW_W;
    import v2yp_pkg::PITCH_W;

    // The DUT is built with its default step count; the predictor follows it,
    // with the step count capped at the length of the arctangent table.
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_DEPTH  = 24;
    localparam int ROT_STEPS    = (CORDIC_STEPS > TABLE_DEPTH) ? TABLE_DEPTH : CORDIC_STEPS;

    // Fixed-point constants of the angle datapath (angles in 1/512 degree,
    // outputs in 1/128 degree).
    localparam longint HALF_TURN_512 = 92160;
    localparam longint YAW_MAX       = 23040;
    localparam longint PITCH_MAX     = 11520;
    localparam longint INV_GAIN_Q20  = 636751;
    localparam int     GAIN_FRAC     = 20;
    localparam longint COMP_SCALE    = 64;

    // Stimulus shape.
    localparam int RANDOM_VECTORS  = 1500;
    localparam int MAX_GAP         = 18;
    localparam int BURST_SPAN      = 150;   // items per gap/stall phase
    localparam int PRESSURE_AT     = 400;  // result count at which the long hold starts
    localparam int PRESSURE_CYCLES = 700;
    localparam int DRAIN_CYCLES    = 4 * ROT_STEPS + 16;
    localparam int IDLE_LIMIT      = 4000;

    typedef struct {
        logic signed [YAW_W-1:0]   yaw;
        logic signed [PITCH_W-1:0] pitch;
    } t_angle_pair;

    // -------------------------------------------------------------------------
    // Scoreboard: predicts yaw and pitch for each vector accepted on the input
    // channel and checks the results on the output channel in order.
    // -------------------------------------------------------------------------
    class yaw_pitch_scoreboard;
        t_angle_pair expected_angles[$];
        int          failures;
        logic signed [YAW_W-1:0] last_yaw;    // mirrors the block's held yaw
        int          atan_deg512[TABLE_DEPTH];

        function new();
            atan_deg512 = '{23040, 13601, 7187, 3648, 1831, 916, 458, 229,
                            115, 57, 29, 14, 7, 4, 2, 1,
                            0, 0, 0, 0, 0, 0, 0, 0};
            failures = 0;
            last_yaw = '0;
        endfunction

        // Vectoring pass: rotates (vx, vy) onto the positive x axis and sums
        // the micro-rotation angles. Shifts are arithmetic, so they floor.
        function void rotate_onto_axis(inout longint vx, inout longint vy,
                                       inout longint ang);
            longint xs;
            longint ys;
            for (int k = 0; k < ROT_STEPS; k++) begin
                xs = vx >>> k;
                ys = vy >>> k;
                if (vy >= 0) begin
                    vx  = vx + ys;
                    vy  = vy - xs;
                    ang = ang + atan_deg512[k];
                end else begin
                    vx  = vx - ys;
                    vy  = vy + xs;
                    ang = ang - atan_deg512[k];
                end
            end
        endfunction

        // 1/512 degree to 1/128 degree, rounding half up, then saturating.
        function longint quarter_round(longint ang, longint lim);
            longint r;
            r = (ang + 2) >>> 2;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function t_angle_pair predict_angles(logic signed [VEC_W-1:0] x,
                                             logic signed [VEC_W-1:0] y,
                                             logic signed [VEC_W-1:0] z);
            t_angle_pair res;
            longint px;
            longint py;
            longint acc;
            longint horiz_len;
            if (x == 0 && y == 0) begin
                // Straight up or down: no horizontal direction, so yaw is zero
                // and pitch is pinned; z = 0 counts as looking up.
                res.yaw   = '0;
                res.pitch = (z > 0) ? PITCH_W'(-PITCH_MAX) : PITCH_W'(PITCH_MAX);
            end else begin
                px  = longint'(x) * COMP_SCALE;
                py  = longint'(y) * COMP_SCALE;
                acc = 0;
                // Left half plane: turn by 180 degrees first, starting the
                // accumulator on the side that y points to (y = 0 gives +180).
                if (px < 0) begin
                    acc = (py >= 0) ? HALF_TURN_512 : -HALF_TURN_512;
                    px  = -px;
                    py  = -py;
                end
                rotate_onto_axis(px, py, acc);
                res.yaw = YAW_W'(quarter_round(acc, YAW_MAX));

                horiz_len = (px * INV_GAIN_Q20 + (longint'(1) << (GAIN_FRAC - 1)))
                            >>> GAIN_FRAC;
                px  = horiz_len;
                py  = -longint'(z) * COMP_SCALE;
                acc = 0;
                rotate_onto_axis(px, py, acc);
                res.pitch = PITCH_W'(quarter_round(acc, PITCH_MAX));
            end
            last_yaw = res.yaw;
            return res;
        endfunction

        function void note_vector(logic signed [VEC_W-1:0] x,
                                  logic signed [VEC_W-1:0] y,
                                  logic signed [VEC_W-1:0] z);
            expected_angles.push_back(predict_angles(x, y, z));
        endfunction

        function void check_result(logic signed [YAW_W-1:0] yaw,
                                   logic signed [PITCH_W-1:0] pitch);
            t_angle_pair exp_pair;
            if (expected_angles.size() == 0) begin
                $error("result yaw=%0d pitch=%0d with no vector outstanding", yaw, pitch);
                failures++;
                return;
            end
            exp_pair = expected_angles.pop_front();
            if (yaw !== exp_pair.yaw) begin
                $error("yaw_angle: expected %0d, actual %0d", exp_pair.yaw, yaw);
                failures++;
            end
            if (pitch !== exp_pair.pitch) begin
                $error("pitch_angle: expected %0d, actual %0d", exp_pair.pitch, pitch);
                failures++;
            end
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // Clock, reset and the DUT. Every input starts at a known value.
    // -------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n    = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic signed [VEC_W-1:0] i_vec_x = '0;
    logic signed [VEC_W-1:0] i_vec_y = '0;
    logic signed [VEC_W-1:0] i_vec_z = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic signed [YAW_W-1:0]   o_yaw_angle;
    logic signed [PITCH_W-1:0] o_pitch_angle;

    yaw_pitch_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    vector_to_yaw_pitch #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_yaw_angle  (o_yaw_angle),
        .o_pitch_angle(o_pitch_angle)
    );

    // -------------------------------------------------------------------------
    // Input side. A vector is offered until a transfer takes it; the payload
    // holds steady while the block stalls. Valid is dropped only when a gap
    // follows, so back-to-back vectors keep valid high without a glitch.
    // -------------------------------------------------------------------------
    task automatic send_vector(input logic signed [VEC_W-1:0] vx,
                               input logic signed [VEC_W-1:0] vy,
                               input logic signed [VEC_W-1:0] vz,
                               input int gap);
        i_in_valid <= 1'b1;
        i_vec_x    <= vx;
        i_vec_y    <= vy;
        i_vec_z    <= vz;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_vector(vx, vy, vz);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Every fourth phase of BURST_SPAN items runs with no gaps at all.
    function automatic int draw_gap(int idx);
        if ((idx / BURST_SPAN) % 4 == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [VEC_W-1:0] corner_value();
        logic signed [VEC_W-1:0] corners[6];
        corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
        return corners[$urandom_range(0, 5)];
    endfunction

    // Random vectors: mostly full range, with extra weight on the cases the
    // datapath treats apart (zero horizontal part, negative x on the axis,
    // tiny components where rounding dominates, and the field corners).
    task automatic pick_vector(output logic signed [VEC_W-1:0] vx,
                               output logic signed [VEC_W-1:0] vy,
                               output logic signed [VEC_W-1:0] vz);
        int pick;
        pick = $urandom_range(0, 99);
        vx = VEC_W'($urandom);
        vy = VEC_W'($urandom);
        vz = VEC_W'($urandom);
        if (pick < 45) begin
            // Full range as drawn.
        end else if (pick < 60) begin
            vx = VEC_W'(int'($urandom_range(0, 16)) - 8);
            vy = VEC_W'(int'($urandom_range(0, 16)) - 8);
            vz = VEC_W'(int'($urandom_range(0, 16)) - 8);
        end else if (pick < 70) begin
            vx = '0;
            vy = '0;
        end else if (pick < 80) begin
            vx = VEC_W'(-int'($urandom_range(1, 32768)));
            vy = '0;
        end else if (pick < 90) begin
            vx = corner_value();
            vy = corner_value();
            vz = corner_value();
        end else begin
            // One component dominant over a tiny one.
            vy = VEC_W'(int'($urandom_range(0, 6)) - 3);
        end
    endtask

    // -------------------------------------------------------------------------
    // Output side. The receiver draws a stall length per result and once holds
    // off for a long stretch so that the block backs up into its input.
    // -------------------------------------------------------------------------
    initial begin
        int hold;
        int taken;
        taken = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == PRESSURE_AT) begin
                hold = PRESSURE_CYCLES;
            end else if ((taken / BURST_SPAN) % 4 == 1) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, MAX_GAP);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
        end
    end

    // Result monitor: a transfer happens at an edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_yaw_angle, o_pitch_angle);
        end
    end

    // Watchdog: a run that stops moving on both channels for too long is a hang.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $error("no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb_vector_to_yaw_pitch NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -------------------------------------------------------------------------
    // Main sequence: reset, directed vectors, random vectors, drain, verdict.
    // -------------------------------------------------------------------------
    initial begin
        logic signed [VEC_W-1:0] dir_x[20];
        logic signed [VEC_W-1:0] dir_y[20];
        logic signed [VEC_W-1:0] dir_z[20];
        logic signed [VEC_W-1:0] rx;
        logic signed [VEC_W-1:0] ry;
        logic signed [VEC_W-1:0] rz;

        sb = new();

        // Directed set: straight up and down (z positive, zero and negative),
        // the four axis directions, negative x on the axis and just below it,
        // field extremes in every sign mix, and a few ordinary directions.
        dir_x = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  16'sd256, -16'sd256, -16'sd256, 16'sd0, 16'sd0,
                  16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd1,
                  16'sd1, -16'sd1, 16'sh8000, 16'sd256, 16'sd100};
        dir_y = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  16'sd0, 16'sd0, -16'sd1, 16'sd256, -16'sd256,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sd0,
                  16'sd1, 16'sd0, 16'sd0, 16'sd256, -16'sd200};
        dir_z = '{16'sd0, 16'sd1, -16'sd1, 16'sh7fff, 16'sh8000,
                  16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                  16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh7fff, 16'sd0, 16'sd0, -16'sd256, 16'sd300};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 20; i++) begin
            send_vector(dir_x[i], dir_y[i], dir_z[i], $urandom_range(0, MAX_GAP));
        end

        for (int i = 0; i < RANDOM_VECTORS; i++) begin
            pick_vector(rx, ry, rz);
            send_vector(rx, ry, rz, draw_gap(i));
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("tb_vector_to_yaw_pitch OK");
        end else begin
            $display("tb_vector_to_yaw_pitch NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/v2yp_pkg.sv
rtl/core/vector_to_yaw_pitch.sv
verif/tb_vector_to_yaw_pitch.sv
